>>> rtl/pwm_duty_capture_backlight_macros.svh
`ifndef PWM_DUTY_CAPTURE_BACKLIGHT_MACROS_SVH
`define PWM_DUTY_CAPTURE_BACKLIGHT_MACROS_SVH

// implication checked in the next cycle
`define PDCB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pdcb assertion failed");

// implication checked in the same cycle
`define PDCB_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pdcb assertion failed");

// state right after a reset cycle
`define PDCB_ASSERT_RESET(lbl, cons) \
  lbl: assert property (@(posedge clk) !rst_n |=> (cons)) \
    else $error("pdcb reset assertion failed");

`endif

>>> rtl/pdcb_pkg.sv
package pdcb_pkg;

  localparam int TICK_BITS   = 16;
  localparam int DUTY_BITS   = 16;
  localparam int BRIGHT_BITS = 8;
  localparam int CFG_W       = 16;
  localparam int MODE_W      = 2;
  localparam int MULT_BITS   = 11;

  localparam int DIV_NUM_W = (TICK_BITS > MULT_BITS) ? DUTY_BITS + TICK_BITS
                                                     : DUTY_BITS + MULT_BITS;
  localparam int DIV_DEN_W = (TICK_BITS + 1 > DUTY_BITS + 2) ? TICK_BITS + 1
                                                             : DUTY_BITS + 2;
  localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

  localparam longint DUTY_MAX_I = (longint'(1) << DUTY_BITS) - 1;

  localparam logic [TICK_BITS-1:0]   TICK_MAX    = '1;
  localparam logic [DUTY_BITS-1:0]   DUTY_MAX    = '1;
  localparam logic [DUTY_BITS-1:0]   DUTY_KNEE   = DUTY_BITS'(4 * DUTY_MAX_I / 5);
  localparam logic [DIV_DEN_W-1:0]   BRIGHT_DEN  = DIV_DEN_W'(4 * DUTY_MAX_I);
  localparam logic [MULT_BITS-1:0]   BRIGHT_MUL  = MULT_BITS'(5 * 255);
  localparam logic [BRIGHT_BITS-1:0] BRIGHT_FULL = '1;

  localparam int EDGE_SLOTS = 3;
  localparam logic [1:0] EDGE_LAST = 2'(EDGE_SLOTS);

  localparam logic [CFG_W-1:0] WINDOW_RST    = CFG_W'(12000);
  localparam logic [CFG_W-1:0] MIN_PHASE_RST = CFG_W'(200);
  localparam logic [BRIGHT_BITS-1:0] HELD_RST = BRIGHT_BITS'(1);

  localparam logic [1:0] REG_WINDOW    = 2'd0;
  localparam logic [1:0] REG_MIN_PHASE = 2'd1;
  localparam logic [1:0] REG_MODE      = 2'd2;

  localparam logic [MODE_W-1:0] MODE_AUTO = 2'd0;
  localparam logic [MODE_W-1:0] MODE_MIN  = 2'd1;

  typedef enum logic [2:0] {
    ST_MEASURED,
    ST_NO_EDGES,
    ST_INCOMPLETE,
    ST_TOO_SHORT,
    ST_FORCED
  } status_t;

  typedef struct packed {
    logic start_req;
    logic pin_level;
  } in_item_t;

  typedef struct packed {
    status_t                status;
    logic [DUTY_BITS-1:0]   duty;
    logic [BRIGHT_BITS-1:0] brightness;
  } out_item_t;

  typedef logic [TICK_BITS-1:0]           tick_t;
  typedef logic [DIV_NUM_W-1:0]           div_num_t;
  typedef logic [DIV_DEN_W-1:0]           div_den_t;
  typedef logic [MULT_BITS+DUTY_BITS-1:0] bmul_t;

  typedef struct packed {
    div_num_t num;
    div_den_t den;
  } div_req_t;

endpackage

>>> rtl/pdcb_div.sv
module pdcb_div (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  pdcb_pkg::div_req_t  req,
  output logic                done,
  output pdcb_pkg::div_num_t  quo
);

  pdcb_pkg::div_num_t sh_r, sh_nxt;
  pdcb_pkg::div_den_t rem_r, rem_nxt;
  pdcb_pkg::div_den_t den_r, den_nxt;
  logic [pdcb_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt;
  logic done_r, done_nxt;

  logic [pdcb_pkg::DIV_DEN_W:0] rem_sh;
  logic [pdcb_pkg::DIV_DEN_W:0] diff;
  logic ge;

  // one quotient bit per cycle, restoring
  always_comb begin
    rem_sh = {rem_r, sh_r[pdcb_pkg::DIV_NUM_W-1]};
    diff   = rem_sh - {1'b0, den_r};
    ge     = rem_sh >= {1'b0, den_r};

    sh_nxt   = sh_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;

    if (start) begin
      sh_nxt   = req.num;
      rem_nxt  = '0;
      den_nxt  = req.den;
      cnt_nxt  = pdcb_pkg::DIV_CNT_W'(pdcb_pkg::DIV_NUM_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      sh_nxt  = {sh_r[pdcb_pkg::DIV_NUM_W-2:0], ge};
      rem_nxt = ge ? diff[pdcb_pkg::DIV_DEN_W-1:0] : rem_sh[pdcb_pkg::DIV_DEN_W-1:0];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == pdcb_pkg::DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sh_r  <= sh_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quo  = sh_r;

endmodule

>>> rtl/pwm_duty_capture_backlight.sv
// results: forced, no-edge and incomplete outcomes are registered from the
//   accepted beat, too short after S_CHECK; a measured result passes S_CHECK,
//   the bit-serial divider (S_DUTY), S_BMUL and the divider again (S_BRIGHT),
//   or skips S_BRIGHT when duty reaches the knee; a result held by out_stall blocks input
// throughput: one beat per cycle while no measurement is being evaluated
// reset: synchronous active low; control registers reset, no result pending
module pwm_duty_capture_backlight (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  pdcb_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output pdcb_pkg::out_item_t             out_data,
  input  logic                            cfg_we,
  input  logic [1:0]                      cfg_index,
  input  logic [pdcb_pkg::CFG_W-1:0]      cfg_data
);

  typedef enum logic [2:0] {
    S_RUN,
    S_CHECK,
    S_DUTY,
    S_BMUL,
    S_BRIGHT
  } state_t;

  state_t state_r, state_nxt;

  logic [pdcb_pkg::CFG_W-1:0]  window_r, window_nxt;
  logic [pdcb_pkg::CFG_W-1:0]  min_phase_r, min_phase_nxt;
  logic [pdcb_pkg::MODE_W-1:0] mode_r, mode_nxt;

  logic measuring_r, measuring_nxt;
  logic init_lvl_r, init_lvl_nxt;
  logic prev_lvl_r, prev_lvl_nxt;
  logic [1:0] edge_cnt_r, edge_cnt_nxt;
  pdcb_pkg::tick_t tick_r, tick_nxt;
  pdcb_pkg::tick_t edge_t_r [pdcb_pkg::EDGE_SLOTS];
  pdcb_pkg::tick_t edge_t_nxt [pdcb_pkg::EDGE_SLOTS];
  logic [pdcb_pkg::BRIGHT_BITS-1:0] held_r, held_nxt;
  logic [pdcb_pkg::DUTY_BITS-1:0]   duty_r, duty_nxt;

  logic                out_valid_r, out_valid_nxt;
  pdcb_pkg::out_item_t out_data_r, out_data_nxt;

  logic               in_accept;
  logic               edge_hit;
  logic [1:0]         cnt_new;
  logic               close_win;
  pdcb_pkg::tick_t    tick_inc;
  pdcb_pkg::tick_t    t0, t1, pulse;
  logic [pdcb_pkg::TICK_BITS:0] period;
  logic               too_short;
  pdcb_pkg::bmul_t    bmul;
  logic [pdcb_pkg::BRIGHT_BITS-1:0] bright_new;

  logic               div_start;
  pdcb_pkg::div_req_t div_req;
  logic               div_done;
  pdcb_pkg::div_num_t div_quo;

  pdcb_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .req   (div_req),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign in_stall  = (state_r != S_RUN) || (out_valid_r && out_stall);
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    tick_inc  = (tick_r != pdcb_pkg::TICK_MAX) ? tick_r + 1'b1 : tick_r;
    edge_hit  = (in_data.pin_level != prev_lvl_r) && (edge_cnt_r != pdcb_pkg::EDGE_LAST);
    cnt_new   = edge_hit ? edge_cnt_r + 1'b1 : edge_cnt_r;
    close_win = (cnt_new == pdcb_pkg::EDGE_LAST) ||
                (32'(tick_inc) >= 32'(window_r)) ||
                (tick_inc == pdcb_pkg::TICK_MAX);

    t0        = edge_t_r[1] - edge_t_r[0];
    t1        = edge_t_r[2] - edge_t_r[1];
    period    = {1'b0, t0} + {1'b0, t1};
    pulse     = init_lvl_r ? t1 : t0;
    too_short = (32'(t0) < 32'(min_phase_r)) || (32'(t1) < 32'(min_phase_r)) ||
                (period == '0);
    bmul      = pdcb_pkg::bmul_t'(duty_r) * pdcb_pkg::bmul_t'(pdcb_pkg::BRIGHT_MUL);
    bright_new = pdcb_pkg::BRIGHT_FULL - div_quo[pdcb_pkg::BRIGHT_BITS-1:0];
  end

  always_comb begin
    state_nxt     = state_r;
    window_nxt    = window_r;
    min_phase_nxt = min_phase_r;
    mode_nxt      = mode_r;
    measuring_nxt = measuring_r;
    init_lvl_nxt  = init_lvl_r;
    prev_lvl_nxt  = prev_lvl_r;
    edge_cnt_nxt  = edge_cnt_r;
    tick_nxt      = tick_r;
    edge_t_nxt    = edge_t_r;
    held_nxt      = held_r;
    duty_nxt      = duty_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    div_start     = 1'b0;
    div_req       = '0;

    if (cfg_we) begin
      case (cfg_index)
        pdcb_pkg::REG_WINDOW:    window_nxt    = cfg_data;
        pdcb_pkg::REG_MIN_PHASE: min_phase_nxt = cfg_data;
        pdcb_pkg::REG_MODE:      mode_nxt      = cfg_data[pdcb_pkg::MODE_W-1:0];
        default: ;
      endcase
    end

    case (state_r)
      S_RUN: begin
        if (in_accept) begin
          if (in_data.start_req) begin
            if (mode_r != pdcb_pkg::MODE_AUTO) begin
              measuring_nxt = 1'b0;
              held_nxt = (mode_r == pdcb_pkg::MODE_MIN) ? '0 : pdcb_pkg::BRIGHT_FULL;
              out_valid_nxt           = 1'b1;
              out_data_nxt.status     = pdcb_pkg::ST_FORCED;
              out_data_nxt.duty       = '0;
              out_data_nxt.brightness = held_nxt;
            end else begin
              measuring_nxt = 1'b1;
              init_lvl_nxt  = in_data.pin_level;
              prev_lvl_nxt  = in_data.pin_level;
              edge_cnt_nxt  = '0;
              tick_nxt      = '0;
            end
          end else if (measuring_r) begin
            tick_nxt     = tick_inc;
            prev_lvl_nxt = in_data.pin_level;
            edge_cnt_nxt = cnt_new;
            if (edge_hit) begin
              edge_t_nxt[edge_cnt_r] = tick_inc;
            end
            if (close_win) begin
              measuring_nxt = 1'b0;
              if (cnt_new == 2'd0) begin
                held_nxt = init_lvl_r ? '0 : pdcb_pkg::BRIGHT_FULL;
                out_valid_nxt           = 1'b1;
                out_data_nxt.status     = pdcb_pkg::ST_NO_EDGES;
                out_data_nxt.duty       = init_lvl_r ? pdcb_pkg::DUTY_MAX : '0;
                out_data_nxt.brightness = held_nxt;
              end else if (cnt_new != pdcb_pkg::EDGE_LAST) begin
                out_valid_nxt           = 1'b1;
                out_data_nxt.status     = pdcb_pkg::ST_INCOMPLETE;
                out_data_nxt.duty       = '0;
                out_data_nxt.brightness = held_r;
              end else begin
                state_nxt = S_CHECK;
              end
            end
          end
        end
      end
      S_CHECK: begin
        if (too_short) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.status     = pdcb_pkg::ST_TOO_SHORT;
          out_data_nxt.duty       = '0;
          out_data_nxt.brightness = held_r;
          state_nxt               = S_RUN;
        end else begin
          // full scale times pulse as a shift and subtract
          div_start   = 1'b1;
          div_req.num = pdcb_pkg::div_num_t'({pulse, {pdcb_pkg::DUTY_BITS{1'b0}}}) -
                        pdcb_pkg::div_num_t'(pulse);
          div_req.den = pdcb_pkg::div_den_t'(period);
          state_nxt   = S_DUTY;
        end
      end
      S_DUTY: begin
        if (div_done) begin
          duty_nxt  = div_quo[pdcb_pkg::DUTY_BITS-1:0];
          state_nxt = S_BMUL;
        end
      end
      S_BMUL: begin
        if (duty_r >= pdcb_pkg::DUTY_KNEE) begin
          held_nxt                = '0;
          out_valid_nxt           = 1'b1;
          out_data_nxt.status     = pdcb_pkg::ST_MEASURED;
          out_data_nxt.duty       = duty_r;
          out_data_nxt.brightness = '0;
          state_nxt               = S_RUN;
        end else begin
          div_start   = 1'b1;
          div_req.num = pdcb_pkg::div_num_t'(bmul);
          div_req.den = pdcb_pkg::BRIGHT_DEN;
          state_nxt   = S_BRIGHT;
        end
      end
      S_BRIGHT: begin
        if (div_done) begin
          held_nxt                = bright_new;
          out_valid_nxt           = 1'b1;
          out_data_nxt.status     = pdcb_pkg::ST_MEASURED;
          out_data_nxt.duty       = duty_r;
          out_data_nxt.brightness = bright_new;
          state_nxt               = S_RUN;
        end
      end
      default: state_nxt = S_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_RUN;
      window_r    <= pdcb_pkg::WINDOW_RST;
      min_phase_r <= pdcb_pkg::MIN_PHASE_RST;
      mode_r      <= pdcb_pkg::MODE_AUTO;
      measuring_r <= 1'b0;
      init_lvl_r  <= 1'b0;
      prev_lvl_r  <= 1'b0;
      edge_cnt_r  <= '0;
      tick_r      <= '0;
      held_r      <= pdcb_pkg::HELD_RST;
      out_valid_r <= 1'b0;
      out_data_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      window_r    <= window_nxt;
      min_phase_r <= min_phase_nxt;
      mode_r      <= mode_nxt;
      measuring_r <= measuring_nxt;
      init_lvl_r  <= init_lvl_nxt;
      prev_lvl_r  <= prev_lvl_nxt;
      edge_cnt_r  <= edge_cnt_nxt;
      tick_r      <= tick_nxt;
      held_r      <= held_nxt;
      out_valid_r <= out_valid_nxt;
      out_data_r  <= out_data_nxt;
    end
  end

  always_ff @(posedge clk) begin
    edge_t_r   <= edge_t_nxt;
    duty_r     <= duty_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> rtl/pdcb_checker.sv
`include "pwm_duty_capture_backlight_macros.svh"

module pdcb_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input pdcb_pkg::out_item_t out_data
);

  logic no_duty;

  assign no_duty = (out_data.status == pdcb_pkg::ST_INCOMPLETE) ||
                   (out_data.status == pdcb_pkg::ST_TOO_SHORT) ||
                   (out_data.status == pdcb_pkg::ST_FORCED);

  // a waiting result is not overwritten
  `PDCB_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

  // no beat taken in while the result register is blocked
  `PDCB_ASSERT_NOW(a_stall_pending, out_valid && out_stall, in_stall)

  // failed or forced outcomes carry no duty
  `PDCB_ASSERT_NOW(a_zero_duty, out_valid && no_duty, out_data.duty == '0)

  // idle and empty right after reset
  `PDCB_ASSERT_RESET(a_reset_idle, !out_valid && !in_stall)

endmodule

bind pwm_duty_capture_backlight pdcb_checker u_pdcb_checker (.*);

>>> bench/tb_pwm_duty_capture_backlight.sv
module tb_pwm_duty_capture_backlight;
  timeunit 1ns;
  timeprecision 1ps;
  import pdcb_pkg::*;

  localparam logic [MODE_W-1:0] MODE_MAX   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
  localparam logic [1:0]        REG_SPARE  = 2'd3;
  localparam longint DUTY_FULL   = 65535;
  localparam int     TICK_TOP    = 65535;
  localparam int     SETTLE      = 80;
  localparam int     QUIET_LIMIT = 4000;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  in_item_t         in_data;
  logic             out_valid;
  logic             out_stall;
  out_item_t        out_data;
  logic             cfg_we;
  logic [1:0]       cfg_index;
  logic [CFG_W-1:0] cfg_data;

  pwm_duty_capture_backlight dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // capture model state
  bit          meas      = 1'b0;
  logic        init_lvl  = 1'b0;
  logic        prev_lvl  = 1'b0;
  int          edge_cnt  = 0;
  int          ticks     = 0;
  int          edge_at[EDGE_SLOTS];
  logic [7:0]  held_br   = 8'd1;
  logic [15:0] win_len   = 16'd12000;
  logic [15:0] min_phase = 16'd200;
  logic [1:0]  mode      = MODE_AUTO;

  out_item_t exp_q[$];
  int        n_bad     = 0;
  int        n_items   = 0;
  int        n_results = 0;
  int        quiet     = 0;
  bit        tx_idle   = 1'b1;
  bit        rx_idle   = 1'b1;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [7:0] bright_for(longint duty);
    if (duty >= 4 * DUTY_FULL / 5)
      return 8'd0;
    return 8'(255 - (1275 * duty) / (4 * DUTY_FULL));
  endfunction

  function automatic void push_result(status_t st, longint duty, logic [7:0] br);
    out_item_t r;
    r.status     = st;
    r.duty       = duty[15:0];
    r.brightness = br;
    exp_q.push_back(r);
  endfunction

  function automatic void close_window();
    longint t0, t1, period, pulse, duty;
    meas = 1'b0;
    if (edge_cnt == 0) begin
      duty = init_lvl ? DUTY_FULL : 0;
      held_br = bright_for(duty);
      push_result(ST_NO_EDGES, duty, held_br);
    end else if (edge_cnt < EDGE_SLOTS) begin
      push_result(ST_INCOMPLETE, 0, held_br);
    end else begin
      t0 = (edge_at[1] - edge_at[0]) & TICK_TOP;
      t1 = (edge_at[2] - edge_at[1]) & TICK_TOP;
      period = t0 + t1;
      pulse = init_lvl ? t1 : t0;
      if (t0 < min_phase || t1 < min_phase || period == 0) begin
        push_result(ST_TOO_SHORT, 0, held_br);
      end else begin
        duty = (DUTY_FULL * pulse) / period;
        held_br = bright_for(duty);
        push_result(ST_MEASURED, duty, held_br);
      end
    end
  endfunction

  function automatic void step_model(in_item_t it);
    if (it.start_req) begin
      n_items++;
      if (mode != MODE_AUTO) begin
        meas = 1'b0;
        held_br = (mode == MODE_MIN) ? 8'd0 : 8'd255;
        push_result(ST_FORCED, 0, held_br);
      end else begin
        meas = 1'b1;
        init_lvl = it.pin_level;
        prev_lvl = it.pin_level;
        edge_cnt = 0;
        ticks = 0;
      end
      return;
    end
    if (!meas)
      return;
    n_items++;
    if (ticks < TICK_TOP)
      ticks++;
    if (it.pin_level != prev_lvl && edge_cnt < EDGE_SLOTS) begin
      edge_at[edge_cnt] = ticks;
      edge_cnt++;
    end
    prev_lvl = it.pin_level;
    if (edge_cnt >= EDGE_SLOTS || ticks >= win_len || ticks >= TICK_TOP)
      close_window();
  endfunction

  function automatic void apply_reg(logic [1:0] idx, logic [CFG_W-1:0] val);
    case (idx)
      REG_WINDOW:    win_len = val;
      REG_MIN_PHASE: min_phase = val;
      REG_MODE:      mode = val[1:0];
      default: ;
    endcase
  endfunction

  function automatic void check_result(out_item_t got);
    out_item_t want;
    n_results++;
    if (exp_q.size() == 0) begin
      n_bad++;
      if (n_bad <= 10)
        $display("unexpected result: status %0d duty %0d brightness %0d",
                 got.status, got.duty, got.brightness);
      return;
    end
    want = exp_q.pop_front();
    if (got.status !== want.status || got.duty !== want.duty ||
        got.brightness !== want.brightness) begin
      n_bad++;
      if (n_bad <= 10) begin
        $display("mismatch: expected status %0d duty %0d brightness %0d",
                 want.status, want.duty, want.brightness);
        $display("          actual   status %0d duty %0d brightness %0d",
                 got.status, got.duty, got.brightness);
      end
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall)
        check_result(out_data);
      if (cfg_we)
        apply_reg(cfg_index, cfg_data);
      if (in_valid && !in_stall)
        step_model(in_data);
      if ((out_valid && !out_stall) || (in_valid && !in_stall) || cfg_we)
        quiet = 0;
      else
        quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("tb_pwm_duty_capture_backlight failed");
        $finish;
      end
    end
  end

  // result side stall
  initial begin
    int gap;
    out_stall = 1'b0;
    @(negedge clk);
    forever begin
      gap = rx_idle ? $urandom_range(0, 11) : 0;
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // called at a falling edge; returns at the falling edge after the beat is taken
  task automatic send_beat(input logic start, input logic pin);
    int gap;
    gap = tx_idle ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= in_item_t'{start_req: start, pin_level: pin};
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] val);
    in_valid <= 1'b0;
    while (exp_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic test_incomplete_keeps_reset_brightness();
    write_reg(REG_WINDOW, 16'd2);
    write_reg(REG_MIN_PHASE, 16'd0);
    send_beat(1'b0, 1'b1);
    send_beat(1'b1, 1'b0);
    send_beat(1'b0, 1'b1);
    send_beat(1'b0, 1'b1);
  endtask

  task automatic test_steady_levels();
    send_beat(1'b1, 1'b1);
    send_beat(1'b0, 1'b1);
    send_beat(1'b0, 1'b1);
    write_reg(REG_WINDOW, 16'd0);
    send_beat(1'b1, 1'b0);
    send_beat(1'b0, 1'b0);
  endtask

  task automatic test_measured_then_too_short();
    write_reg(REG_WINDOW, 16'd20);
    send_beat(1'b1, 1'b1);
    send_beat(1'b0, 1'b0);
    send_beat(1'b0, 1'b1);
    send_beat(1'b0, 1'b1);
    send_beat(1'b0, 1'b1);
    send_beat(1'b0, 1'b0);
    write_reg(REG_MIN_PHASE, 16'hFFFF);
    send_beat(1'b1, 1'b0);
    send_beat(1'b0, 1'b1);
    send_beat(1'b0, 1'b0);
    send_beat(1'b0, 1'b1);
  endtask

  task automatic test_restart_and_mode_switch();
    write_reg(REG_MIN_PHASE, 16'd0);
    write_reg(REG_WINDOW, 16'd3);
    send_beat(1'b1, 1'b0);
    send_beat(1'b0, 1'b1);
    send_beat(1'b1, 1'b1);
    send_beat(1'b0, 1'b1);
    send_beat(1'b0, 1'b1);
    write_reg(REG_MODE, CFG_W'(MODE_MAX));
    send_beat(1'b0, 1'b1);
  endtask

  task automatic test_forced_modes();
    send_beat(1'b1, 1'b0);
    write_reg(REG_MODE, CFG_W'(MODE_MIN));
    send_beat(1'b1, 1'b1);
    write_reg(REG_MODE, CFG_W'(MODE_SPARE));
    send_beat(1'b1, 1'b0);
    write_reg(REG_SPARE, 16'hFFFF);
    write_reg(REG_MODE, CFG_W'(MODE_AUTO));
  endtask

  task automatic random_config();
    logic [CFG_W-1:0] val;
    if ($urandom_range(0, 1)) begin
      case ($urandom_range(0, 9))
        0:       val = 16'd1;
        1:       val = 16'hFFFF;
        default: val = 16'($urandom_range(4, 60));
      endcase
      write_reg(REG_WINDOW, val);
    end
    if ($urandom_range(0, 1)) begin
      case ($urandom_range(0, 9))
        0:       val = 16'hFFFF;
        1:       val = 16'($urandom_range(0, 65535));
        default: val = 16'($urandom_range(0, 6));
      endcase
      write_reg(REG_MIN_PHASE, val);
    end
    if ($urandom_range(0, 1)) begin
      case ($urandom_range(0, 9))
        7:       val = CFG_W'(MODE_MIN);
        8:       val = CFG_W'(MODE_MAX);
        9:       val = CFG_W'(MODE_SPARE);
        default: val = CFG_W'(MODE_AUTO);
      endcase
      write_reg(REG_MODE, val);
    end
    if ($urandom_range(0, 15) == 0)
      write_reg(REG_SPARE, 16'($urandom_range(0, 65535)));
  endtask

  // start then alternating phases of random length until the window closes or a guard of 300 beats runs out
  task automatic pwm_burst();
    logic lvl;
    int   len;
    int   guard;
    lvl = 1'($urandom_range(0, 1));
    send_beat(1'b1, lvl);
    len = $urandom_range(0, 12);
    guard = 0;
    while (meas && guard < 300) begin
      for (int k = 0; k < len && meas; k++) begin
        send_beat(1'b0, lvl);
        guard++;
      end
      lvl = ~lvl;
      len = $urandom_range(1, 12);
    end
  endtask

  task automatic noise_burst();
    repeat ($urandom_range(1, 8))
      send_beat($urandom_range(0, 3) == 0, 1'($urandom_range(0, 1)));
  endtask

  task automatic broken_burst();
    send_beat(1'b1, 1'($urandom_range(0, 1)));
    repeat ($urandom_range(1, 5))
      send_beat(1'b0, 1'($urandom_range(0, 1)));
  endtask

  task automatic test_random_pwm();
    while (n_items < 340 || n_results < 40) begin
      if ($urandom_range(0, 7) == 0)
        random_config();
      tx_idle = ($urandom_range(0, 4) != 0);
      rx_idle = ($urandom_range(0, 4) != 0);
      case ($urandom_range(0, 9))
        0:       noise_burst();
        1:       broken_burst();
        default: pwm_burst();
      endcase
    end
  endtask

  // largest window with a short pwm period, back to back
  task automatic test_full_window();
    write_reg(REG_WINDOW, 16'hFFFF);
    write_reg(REG_MIN_PHASE, 16'd0);
    write_reg(REG_MODE, CFG_W'(MODE_AUTO));
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    send_beat(1'b1, 1'b0);
    repeat (20) send_beat(1'b0, 1'b0);
    repeat (12) send_beat(1'b0, 1'b1);
    repeat (5) send_beat(1'b0, 1'b0);
    send_beat(1'b0, 1'b1);
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = REG_WINDOW;
    cfg_data  = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_incomplete_keeps_reset_brightness();
    test_steady_levels();
    test_measured_then_too_short();
    test_restart_and_mode_switch();
    test_forced_modes();
    test_random_pwm();
    test_full_window();

    in_valid <= 1'b0;
    while (exp_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    if (n_bad == 0 && exp_q.size() == 0)
      $display("tb_pwm_duty_capture_backlight passed");
    else
      $display("tb_pwm_duty_capture_backlight failed");
    $finish;
  end

endmodule

>>> pwm_duty_capture_backlight.f
+incdir+rtl
rtl/pdcb_pkg.sv
rtl/pdcb_div.sv
rtl/pwm_duty_capture_backlight.sv
rtl/pdcb_checker.sv
bench/tb_pwm_duty_capture_backlight.sv
